[rtl/lssr_pkg.sv]
// ----------------------------------------------------------------------------
// lssr_pkg: shared types and constants
// Sizes, matrix selects and fixed-point helpers for the state-space block.
// ----------------------------------------------------------------------------
package lssr_pkg;

    localparam int STATE_MAX  = 8;
    localparam int INPUT_MAX  = 8;
    localparam int OUTPUT_MAX = 8;
    localparam int NCELL      = 8;
    localparam int IW         = 3;
    localparam int ACC_W      = 36;

    localparam logic [1:0] SEL_A = 2'd0;
    localparam logic [1:0] SEL_B = 2'd1;
    localparam logic [1:0] SEL_C = 2'd2;
    localparam logic [1:0] SEL_D = 2'd3;

    localparam logic [1:0] REG_STATE  = 2'd0;
    localparam logic [1:0] REG_INPUT  = 2'd1;
    localparam logic [1:0] REG_OUTPUT = 2'd2;

    // Word handed from one cell to the next
    typedef struct packed {
        logic        vld;
        logic        last_op;
        logic [IW-1:0] row;
        logic signed [15:0] operand;
    } t_link;

    // Clamp a size register to 1..max
    function automatic logic [3:0] clamp_size(input logic [3:0] v, input logic [3:0] mx);
        logic [3:0] r;
        begin
            r = v;
            if (v == 4'd0) r = 4'd1;
            else if (v > mx) r = mx;
            return r;
        end
    endfunction

    // Round half up at bit 12, saturate to 16 bits
    function automatic logic signed [15:0] round_sat(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] s;
        logic signed [ACC_W-13:0] q;
        logic signed [15:0] r;
        begin
            s = acc + ACC_W'(2048);
            q = s[ACC_W-1:12];
            if (q > 32767) r = 16'sh7fff;
            else if (q < -32768) r = 16'sh8000;
            else r = q[15:0];
            return r;
        end
    endfunction

endpackage

[rtl/linear_state_space_recurrence.sv]
// ----------------------------------------------------------------------------
// linear_state_space_recurrence: discrete linear state-space step
// Loads A, B, C, D, buffers the input vector and runs h=Ah+Bx, y=Ch+Dx.
// ----------------------------------------------------------------------------
// Usage:
//   Input words with i_kind=0 load one coefficient each.
//   Words with i_kind=1 carry one x element; the last element of a step
//   starts the computation and the input stalls until its results are out.
//   Each result row is one sum over N=state_size+input_size terms, computed
//   by a chain of 8 cells: each cell owns one row index of the output, the
//   operand (h_j or x_j) walks down the chain, one term per cycle.
//   A step runs a state-update pass, emits the state results, then runs a
//   readout pass; each pass feeds N operands down the cell chain and drains
//   it, and results leave one word per cycle while i_stall is low.
//   Results leave in order: state elements, then outputs; o_last marks the
//   final one. A stalled result holds; the engine waits for it.
//   Reset clears control state, the hidden state and sets all sizes to 8.
//   Config writes are taken only while the block is idle.
// ----------------------------------------------------------------------------
module linear_state_space_recurrence
    import lssr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_kind,
    input  logic [1:0]  i_matrix_select,
    input  logic [2:0]  i_row,
    input  logic [2:0]  i_column,
    input  logic signed [15:0] i_value,
    input  logic        i_new_sequence,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [3:0]  i_cfg_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_result_kind,
    output logic [2:0]  o_index,
    output logic signed [15:0] o_result_value,
    output logic        o_last
);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_FEED = 3'd1;
    localparam logic [2:0] ST_WAIT = 3'd2;
    localparam logic [2:0] ST_EMIT = 3'd3;

    logic [2:0] r_st;
    logic r_phase;            // 0: state update, 1: readout
    logic [3:0] r_ssz, r_isz, r_osz, r_cnt;
    logic signed [15:0] r_h [0:NCELL-1];
    logic signed [15:0] r_x [0:NCELL-1];
    logic [4:0] r_k;          // operand counter
    logic [4:0] r_w;          // drain counter
    logic [3:0] r_e;          // emit index
    logic signed [15:0] r_res [0:NCELL-1];
    logic r_clr;
    t_link w_feed;
    t_link w_lk [0:NCELL];
    logic signed [ACC_W-1:0] w_acc [0:NCELL-1];
    logic [1:0] w_msel;
    logic w_acc_in, w_done_in, w_wr;
    logic [4:0] w_n;
    logic [3:0] w_lim;

    assign w_acc_in = i_valid && !o_stall;
    assign w_done_in = w_acc_in && i_kind && (r_cnt + 4'd1 >= r_isz);
    assign o_stall = (r_st != ST_IDLE);
    assign o_cfg_ready = (r_st == ST_IDLE) && !i_valid;
    assign w_wr = w_acc_in && !i_kind;
    assign w_n = 5'(r_ssz) + 5'(r_isz);
    assign w_lim = r_phase ? r_osz : r_ssz;

    // operand feed: state terms then input terms; matrix A/B or C/D
    always_comb begin
        w_feed = '0;
        w_msel = SEL_A;
        if (r_st == ST_FEED) begin
            w_feed.vld = 1'b1;
            if (r_k < 5'(r_ssz)) begin
                w_feed.row = r_k[IW-1:0];
                w_feed.operand = r_h[r_k[IW-1:0]];
                w_msel = r_phase ? SEL_C : SEL_A;
            end else begin
                w_feed.row = 3'(r_k - 5'(r_ssz));
                w_feed.operand = r_x[w_feed.row];
                w_msel = r_phase ? SEL_D : SEL_B;
            end
        end
    end

    // the operand and its select walk the chain
    genvar g;
    logic [1:0] r_msel [0:NCELL-2];
    logic [1:0] w_msel_lk [0:NCELL-1];
    always_ff @(posedge i_clk) begin
        r_msel[0] <= w_msel;
        for (int c = 1; c < NCELL - 1; c++) r_msel[c] <= r_msel[c-1];
    end

    assign w_msel_lk[0] = w_msel;
    generate
        for (g = 1; g < NCELL; g++) begin : g_msel
            assign w_msel_lk[g] = r_msel[g-1];
        end
    endgenerate

    assign w_lk[0] = w_feed;
    generate
        for (g = 0; g < NCELL; g++) begin : g_cell
            lssr_cell u_cell (
                .i_clk  (i_clk),
                .i_clr  (r_clr),
                .i_link (w_lk[g]),
                .i_msel (w_msel_lk[g]),
                .i_wr   (w_wr && i_row == 3'(g)),
                .i_wsel (i_matrix_select),
                .i_wrow (i_column),
                .i_wdata(i_value),
                .o_link (w_lk[g+1]),
                .o_acc  (w_acc[g])
            );
        end
    endgenerate

    // control
    always_ff @(posedge i_clk) begin
        r_clr <= 1'b0;
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
            r_ssz <= 4'd8; r_isz <= 4'd8; r_osz <= 4'd8;
            r_cnt <= '0; r_phase <= 1'b0; r_clr <= 1'b1;
            for (int c = 0; c < NCELL; c++) r_h[c] <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    REG_STATE:  begin r_ssz <= clamp_size(i_cfg_data, 4'(STATE_MAX));  r_cnt <= '0; end
                    REG_INPUT:  begin r_isz <= clamp_size(i_cfg_data, 4'(INPUT_MAX));  r_cnt <= '0; end
                    REG_OUTPUT: begin r_osz <= clamp_size(i_cfg_data, 4'(OUTPUT_MAX)); r_cnt <= '0; end
                    default: ;
                endcase
            end
            unique case (r_st)
                ST_IDLE: if (w_acc_in && i_kind) begin
                    if (i_new_sequence)
                        for (int c = 0; c < NCELL; c++) r_h[c] <= '0;
                    r_x[r_cnt[IW-1:0]] <= i_value;
                    if (w_done_in) begin
                        r_cnt <= '0; r_st <= ST_FEED; r_k <= '0; r_phase <= 1'b0;
                        r_clr <= 1'b1;
                    end else r_cnt <= r_cnt + 4'd1;
                end
                ST_FEED: begin
                    r_k <= r_k + 5'd1;
                    if (r_k + 5'd1 == w_n) begin r_st <= ST_WAIT; r_w <= '0; end
                end
                ST_WAIT: begin
                    r_w <= r_w + 5'd1;
                    if (r_w == 5'(NCELL + 3)) begin
                        // state rows beyond the current size keep their value
                        for (int c = 0; c < NCELL; c++) begin
                            r_res[c] <= round_sat(w_acc[c]);
                            if (!r_phase && 4'(c) < r_ssz) r_h[c] <= round_sat(w_acc[c]);
                        end
                        r_e <= '0; r_st <= ST_EMIT;
                    end
                end
                ST_EMIT: if (!i_stall) begin
                    r_e <= r_e + 4'd1;
                    if (r_e + 4'd1 == w_lim) begin
                        if (r_phase) r_st <= ST_IDLE;
                        else begin
                            r_phase <= 1'b1; r_st <= ST_FEED; r_k <= '0; r_clr <= 1'b1;
                        end
                    end
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end

    assign o_valid = (r_st == ST_EMIT);
    assign o_result_kind = r_phase;
    assign o_index = r_e[IW-1:0];
    assign o_result_value = r_res[r_e[IW-1:0]];
    assign o_last = r_phase && (r_e + 4'd1 == r_osz);
endmodule

[rtl/lssr_cell.sv]
// ----------------------------------------------------------------------------
// lssr_cell: one column of the MAC chain
// Holds one coefficient row per matrix and one accumulator; passes the
// operand word to its neighbor each cycle, adding coef*operand to its sum.
// ----------------------------------------------------------------------------
module lssr_cell
    import lssr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_clr,
    input  t_link       i_link,
    input  logic [1:0]  i_msel,
    input  logic        i_wr,
    input  logic [1:0]  i_wsel,
    input  logic [IW-1:0] i_wrow,
    input  logic signed [15:0] i_wdata,
    output t_link       o_link,
    output logic signed [ACC_W-1:0] o_acc
);
    logic signed [15:0] r_mem [0:4*NCELL-1];
    logic signed [15:0] r_coef;
    t_link r_link;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [31:0] r_prod;
    logic r_pv;

    // coefficient store, one row of A, B, C and D
    always_ff @(posedge i_clk) begin
        if (i_wr) r_mem[{i_wsel, i_wrow}] <= i_wdata;
        r_coef <= r_mem[{i_msel, i_link.row}];
    end

    // pass operand on, multiply, then accumulate
    always_ff @(posedge i_clk) begin
        r_link <= i_link;
        r_prod <= r_coef * r_link.operand;
        r_pv   <= r_link.vld;
        if (i_clr) r_acc <= '0;
        else if (r_pv) r_acc <= r_acc + ACC_W'(r_prod);
    end

    assign o_link = r_link;
    assign o_acc  = r_acc;
endmodule

[rtl/lssr_checker.sv]
// ----------------------------------------------------------------------------
// lssr_checker: port-level checks
// Watches the handshakes and result ordering at the top level.
// ----------------------------------------------------------------------------
module lssr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic        o_stall,
    input logic        o_cfg_ready,
    input logic        o_last,
    input logic        o_result_kind,
    input logic [2:0]  o_index,
    input logic signed [15:0] o_result_value
);
    // a stalled result word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_result_value) && $stable(o_index))
        else $error("result changed under stall");
    // last only on output elements
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |-> o_result_kind)
        else $error("last on state element");
    // no input taken while results are pending
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall && !o_cfg_ready)
        else $error("input open during emit");
endmodule

bind linear_state_space_recurrence lssr_checker u_chk (.*);

[test/linear_state_space_recurrence_check.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// linear_state_space_recurrence_check: result predictor and comparator
// Watches the input, config and result channels, keeps its own copy of the
// coefficients, hidden state and sizes, and compares every result word in
// order against the predicted queue.
// ----------------------------------------------------------------------------
module linear_state_space_recurrence_check
    import lssr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_in_stall,
    input  logic        i_kind,
    input  logic [1:0]  i_matrix_select,
    input  logic [2:0]  i_row,
    input  logic [2:0]  i_column,
    input  logic signed [15:0] i_value,
    input  logic        i_new_sequence,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [3:0]  i_cfg_data,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic        i_result_kind,
    input  logic [2:0]  i_index,
    input  logic signed [15:0] i_result_value,
    input  logic        i_last,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic               kind;
        logic [2:0]         idx;
        logic signed [15:0] val;
        logic               last;
    } t_result;

    logic signed [15:0] mat_a [8][8];
    logic signed [15:0] mat_b [8][8];
    logic signed [15:0] mat_c [8][8];
    logic signed [15:0] mat_d [8][8];
    logic signed [15:0] hstate [8];
    logic signed [15:0] xbuf [8];
    int                 elem_cnt;
    int                 n_state, n_input, n_output;
    int                 fail_cnt = 0;
    t_result            expected_results [$];

    assign o_pending = expected_results.size();
    assign o_fail_count = fail_cnt;

    function automatic int size_clamp(logic [3:0] v);
        if (v == 0) return 1;
        if (v > 8) return 8;
        return int'(v);
    endfunction

    // round half up at bit 12, saturate
    function automatic logic signed [15:0] rnd_sat(longint acc);
        longint q;
        q = (acc + 2048) >>> 12;
        if (q > 32767) return 16'sh7fff;
        if (q < -32768) return 16'sh8000;
        return q[15:0];
    endfunction

    task automatic report(string what, t_result got, t_result want);
        $display("MISMATCH %s: got k=%0d i=%0d v=%0d l=%0d want k=%0d i=%0d v=%0d l=%0d",
                 what, got.kind, got.idx, got.val, got.last,
                 want.kind, want.idx, want.val, want.last);
        fail_cnt++;
    endtask

    task automatic predict_step();
        logic signed [15:0] hn [8];
        longint acc;
        t_result r;
        for (int i = 0; i < n_state; i++) begin
            acc = 0;
            for (int j = 0; j < n_state; j++) acc += longint'(mat_a[i][j]) * hstate[j];
            for (int j = 0; j < n_input; j++) acc += longint'(mat_b[i][j]) * xbuf[j];
            hn[i] = rnd_sat(acc);
        end
        for (int i = 0; i < n_state; i++) begin
            hstate[i] = hn[i];
            r = '{1'b0, 3'(i), hn[i], 1'b0};
            expected_results.push_back(r);
        end
        for (int i = 0; i < n_output; i++) begin
            acc = 0;
            for (int j = 0; j < n_state; j++) acc += longint'(mat_c[i][j]) * hstate[j];
            for (int j = 0; j < n_input; j++) acc += longint'(mat_d[i][j]) * xbuf[j];
            r = '{1'b1, 3'(i), rnd_sat(acc), i + 1 == n_output};
            expected_results.push_back(r);
        end
    endtask

    always @(posedge i_clk) begin
        t_result got, want;
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) begin
                hstate[i] = 0;
                for (int j = 0; j < 8; j++) begin
                    mat_a[i][j] = 0; mat_b[i][j] = 0;
                    mat_c[i][j] = 0; mat_d[i][j] = 0;
                end
            end
            elem_cnt = 0;
            n_state = 8; n_input = 8; n_output = 8;
        end else begin
            // config write
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_STATE:  n_state  = size_clamp(i_cfg_data);
                    REG_INPUT:  n_input  = size_clamp(i_cfg_data);
                    REG_OUTPUT: n_output = size_clamp(i_cfg_data);
                    default: ;
                endcase
                if (i_cfg_index <= REG_OUTPUT) elem_cnt = 0;
            end
            // input word
            if (i_valid && !i_in_stall) begin
                if (!i_kind) begin
                    case (i_matrix_select)
                        SEL_A: mat_a[i_row][i_column] = i_value;
                        SEL_B: mat_b[i_row][i_column] = i_value;
                        SEL_C: mat_c[i_row][i_column] = i_value;
                        default: mat_d[i_row][i_column] = i_value;
                    endcase
                end else begin
                    if (i_new_sequence)
                        for (int i = 0; i < 8; i++) hstate[i] = 0;
                    if (elem_cnt < 8) xbuf[elem_cnt] = i_value;
                    elem_cnt++;
                    if (elem_cnt >= n_input) begin
                        elem_cnt = 0;
                        predict_step();
                    end
                end
            end
            // result word
            if (i_out_valid && !i_out_stall) begin
                got = '{i_result_kind, i_index, i_result_value, i_last};
                if (expected_results.size() == 0) begin
                    report("unexpected result word", got, '0);
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) report("result word", got, want);
                end
            end
        end
    end

endmodule

[test/linear_state_space_recurrence_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// linear_state_space_recurrence_test: stimulus and verdict
// Loads a full coefficient set, runs directed extreme steps and then random
// steps over several size settings with random idling on both sides.
// ----------------------------------------------------------------------------
module linear_state_space_recurrence_test;
    import lssr_pkg::*;

    localparam logic [1:0] REG_UNUSED = 2'd3;

    logic               clk = 0;
    logic               rst_n = 0;
    logic               in_valid = 0;
    logic               in_stall;
    logic               kind = 0;
    logic [1:0]         msel = SEL_A;
    logic [2:0]         row = 0, col = 0;
    logic signed [15:0] value = 0;
    logic               new_seq = 0;
    logic               cfg_valid = 0;
    logic               cfg_ready;
    logic [1:0]         cfg_index = REG_STATE;
    logic [3:0]         cfg_data = 0;
    logic               out_valid;
    logic               out_stall = 0;
    logic               res_kind, res_last;
    logic [2:0]         res_index;
    logic signed [15:0] res_value;
    int                 fail_count, pending;

    always begin
        #5 clk = 1;
        #5 clk = 0;
    end

    linear_state_space_recurrence dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .o_stall(in_stall),
        .i_kind(kind), .i_matrix_select(msel), .i_row(row), .i_column(col),
        .i_value(value), .i_new_sequence(new_seq), .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_valid(out_valid), .i_stall(out_stall), .o_result_kind(res_kind),
        .o_index(res_index), .o_result_value(res_value), .o_last(res_last)
    );

    linear_state_space_recurrence_check chk (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .i_in_stall(in_stall),
        .i_kind(kind), .i_matrix_select(msel), .i_row(row), .i_column(col),
        .i_value(value), .i_new_sequence(new_seq), .i_cfg_valid(cfg_valid),
        .i_cfg_ready(cfg_ready), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_result_kind(res_kind),
        .i_index(res_index), .i_result_value(res_value), .i_last(res_last),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // random edge-heavy Q3.12 value
    function automatic logic signed [15:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'(int'($urandom_range(0, 8192)) - 4096);
            default: return 16'($urandom);
        endcase
    endfunction

    // one input word; random gap, then hold until accepted
    // valid stays up after acceptance until the next call or an idle task
    task automatic send_word(logic k, logic [1:0] s, logic [2:0] r, logic [2:0] c,
                             logic signed [15:0] v, logic ns, bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 10) : 0;
        cfg_valid <= 1'b0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1; kind <= k; msel <= s; row <= r; col <= c;
        value <= v; new_seq <= ns;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        cfg_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    // valid stays up after the write until the next word or idle task
    task automatic write_reg(logic [1:0] idx, logic [3:0] d);
        in_valid <= 1'b0;
        cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= d;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    // every coefficient at full scale
    task automatic load_all();
        for (int s = 0; s < 4; s++)
            for (int r = 0; r < 8; r++)
                for (int c = 0; c < 8; c++)
                    send_word(1'b0, 2'(s), 3'(r), 3'(c), 16'sh7fff, 1'b0,
                              $urandom_range(0, 3) == 0);
    endtask

    // overwrite random coefficients; mode 1 negative full scale,
    // mode 3 small values, otherwise edge-heavy values
    task automatic load_some(int n, int mode);
        logic signed [15:0] v;
        for (int i = 0; i < n; i++) begin
            if (mode == 1) v = 16'sh8000;
            else if (mode == 3) v = 16'(int'($urandom_range(0, 2048)) - 1024);
            else v = pick_value();
            send_word(1'b0, 2'($urandom), 3'($urandom), 3'($urandom), v, 1'b0,
                      $urandom_range(0, 3) == 0);
        end
    endtask

    // output-side stall: a random-length stall after an accepted word while stall_on is set
    int stall_left = 0;
    bit stall_on = 1;
    always @(posedge clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_stall <= 1;
        end else if (out_valid && out_stall) begin
            out_stall <= 0;
        end else if (out_valid && !out_stall && stall_on) begin
            stall_left <= $urandom_range(0, 10);
            out_stall <= 0;
        end else begin
            out_stall <= 0;
        end
    end

    initial begin
        #50_000_000;
        $display("Verification failed");
        $finish;
    end

    initial begin
        int ns, ni;
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // directed: saturating extremes with all sizes at 8
        load_all();
        for (int i = 0; i < 8; i++)
            send_word(1'b1, SEL_A, 3'd0, 3'd0, 16'sh7fff, 1'(i == 0), 1'b0);
        for (int i = 0; i < 8; i++)
            send_word(1'b1, SEL_A, 3'd0, 3'd0, 16'sh8000, 1'b0, 1'b0);
        drain();
        load_some(16, 1);
        // new_sequence mid vector; coefficient load mid vector
        send_word(1'b1, SEL_A, 3'd0, 3'd0, 16'sh0001, 1'b0, 1'b0);
        send_word(1'b1, SEL_A, 3'd0, 3'd0, 16'sh7fff, 1'b1, 1'b0);
        send_word(1'b0, SEL_D, 3'd7, 3'd7, 16'sh1000, 1'b0, 1'b0);
        for (int i = 0; i < 6; i++)
            send_word(1'b1, SEL_A, 3'd0, 3'd0, 16'(i * 1111 - 3000), 1'b0, 1'b0);
        drain();
        // sizes 0 (clamped to 1) and 15 (clamped to 8); partial vector dropped
        send_word(1'b1, SEL_A, 3'd0, 3'd0, 16'sh4000, 1'b0, 1'b0);
        write_reg(REG_STATE, 4'd0); write_reg(REG_INPUT, 4'd0); write_reg(REG_OUTPUT, 4'd0);
        write_reg(REG_UNUSED, 4'd5);
        send_word(1'b1, SEL_A, 3'd0, 3'd0, 16'sh7fff, 1'b0, 1'b0);
        send_word(1'b1, SEL_A, 3'd0, 3'd0, 16'sh8000, 1'b1, 1'b0);
        drain();
        write_reg(REG_STATE, 4'd15); write_reg(REG_INPUT, 4'd15);
        write_reg(REG_OUTPUT, 4'd15);
        load_some(16, 3);
        for (int i = 0; i < 8; i++)
            send_word(1'b1, SEL_A, 3'd0, 3'd0, 16'sh1000, 1'b0, 1'b0);
        drain();
        // random phases over size settings
        for (int ph = 0; ph < 10; ph++) begin
            ns = ph < 2 ? 8 : $urandom_range(1, 8);
            ni = ph == 2 ? 1 : $urandom_range(1, 8);
            write_reg(REG_STATE, 4'(ns));
            write_reg(REG_INPUT, 4'(ni));
            write_reg(REG_OUTPUT, 4'(ph == 3 ? 1 : $urandom_range(1, 8)));
            stall_on = ph % 3 != 1;
            load_some(8, ph % 2 == 0 ? 3 : 2);
            for (int st = 0; st < 8 / ni + 2; st++) begin
                for (int e = 0; e < ni; e++)
                    send_word(1'b1, SEL_A, 3'd0, 3'd0, pick_value(),
                              e == 0 && $urandom_range(0, 7) == 0, ph % 3 != 1);
                if ($urandom_range(0, 9) == 0)
                    send_word(1'b0, 2'($urandom), 3'($urandom), 3'($urandom),
                              pick_value(), 1'($urandom), 1'b1);
            end
            drain();
        end
        drain();
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
